@@ design/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and codes for the palette pixel converter and scaler.
// ----------------------------------------------------------------------------
package ppc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PIXEL_MODE   = 3'd0;
    localparam logic [2:0] REG_SCALE_FACTOR = 3'd1;
    localparam logic [2:0] REG_RED_MASK     = 3'd2;
    localparam logic [2:0] REG_GREEN_MASK   = 3'd3;
    localparam logic [2:0] REG_BLUE_MASK    = 3'd4;

    // pixel modes
    localparam logic [1:0] MODE_INDEXED = 2'd0;
    localparam logic [1:0] MODE_TC16    = 2'd1;

    // request kinds
    localparam logic REQ_PALETTE_WRITE = 1'b0;
    localparam logic REQ_PIXEL         = 1'b1;

    localparam int CHAN_BITS  = 8;
    localparam int WORD_BITS  = 32;
    localparam int SHIFT_BITS = 5;
    localparam int WID_BITS   = 4;

    // cycles that requests are held off after a mask write while it is decoded
    localparam logic [1:0] DECODE_LATENCY = 2'd2;

    localparam logic [2:0] SCALE_RESET = 3'd2;

    // decoded placement of one colour channel
    typedef struct packed {
        logic [SHIFT_BITS-1:0] sh;
        logic [WID_BITS-1:0]   wid;
    } t_field;

endpackage

@@ design/ppc_ram.sv @@
// ----------------------------------------------------------------------------
// ppc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/ppc_field_decode.sv @@
// ----------------------------------------------------------------------------
// ppc_field_decode
// Turns a channel field mask into a shift and a width clamped to 8 bits,
// over two register stages.
// ----------------------------------------------------------------------------
module ppc_field_decode (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ppc_pkg::WORD_BITS-1:0]     i_mask,
    output ppc_pkg::t_field                   o_field
);

    logic [ppc_pkg::SHIFT_BITS-1:0] r_tz;
    logic [ppc_pkg::SHIFT_BITS-1:0] n_tz;
    logic [ppc_pkg::WORD_BITS-1:0]  aligned;
    logic [ppc_pkg::WID_BITS-1:0]   n_wid;
    logic                           run;
    ppc_pkg::t_field                r_field;

    // trailing zero count
    always_comb begin
        n_tz = '0;
        for (int i = ppc_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (i_mask[i]) begin
                n_tz = ppc_pkg::SHIFT_BITS'(i);
            end
        end
    end

    // run of ones above the shift, at most 8 counted
    always_comb begin
        aligned = i_mask >> r_tz;
        run     = 1'b1;
        n_wid   = '0;
        for (int i = 0; i < ppc_pkg::CHAN_BITS; i++) begin
            run   = run & aligned[i];
            n_wid = n_wid + ppc_pkg::WID_BITS'(run);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz    <= '0;
            r_field <= '0;
        end else begin
            r_tz        <= n_tz;
            r_field.sh  <= r_tz;
            r_field.wid <= n_wid;
        end
    end

    assign o_field = r_field;

endmodule

@@ design/palette_pixel_converter_scaler_core.sv @@
// ----------------------------------------------------------------------------
// palette_pixel_converter_scaler_core
// Palette entry writes (not in indexed mode) pack r, g, b into a true-colour table;
// pixel requests read the table (or pass the index) and repeat the word scale times (1..MAX_SCALE).
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata index,red,green,blue; tuser req_type
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata pixel_value; tlast run_end
//  cfg       in   i_cfg_wr_en                  i_cfg_addr, i_cfg_wdata
//
//  a pixel is repeated scale times on m_axis, set by the output repeat counter,
//  one copy per cycle while m_axis_tready is high
//  a pixel waits in the table read stage behind the registered ram until the output stage is free
//  a new request is taken while the previous pixel is still being repeated, if the read stage is empty
//  s_axis_tready drops after a mask write while the mask is decoded
//  reset clears the table through per-entry valid bits at once
// ----------------------------------------------------------------------------
module palette_pixel_converter_scaler_core #(
    parameter int PALETTE_SIZE = 256,
    parameter int MAX_SCALE    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] index, [15:8] red, [23:16] green, [31:24] blue
    input  logic        s_axis_tuser,   // [0] req_type

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] pixel_value
    output logic        m_axis_tlast,

    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    localparam int AW = $clog2(PALETTE_SIZE);
    localparam int RW = $clog2(MAX_SCALE + 1);

    // configuration
    logic [1:0]  r_mode;
    logic [2:0]  r_scale;
    logic [31:0] r_red_mask;
    logic [31:0] r_green_mask;
    logic [31:0] r_blue_mask;
    logic [1:0]  r_busy;

    ppc_pkg::t_field red_field;
    ppc_pkg::t_field green_field;
    ppc_pkg::t_field blue_field;

    logic mask_wr;
    assign mask_wr = i_cfg_wr_en && (i_cfg_addr inside {ppc_pkg::REG_RED_MASK,
                     ppc_pkg::REG_GREEN_MASK, ppc_pkg::REG_BLUE_MASK});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ppc_pkg::MODE_INDEXED;
            r_scale      <= ppc_pkg::SCALE_RESET;
            r_red_mask   <= '0;
            r_green_mask <= '0;
            r_blue_mask  <= '0;
            r_busy       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    ppc_pkg::REG_PIXEL_MODE:   r_mode       <= i_cfg_wdata[1:0];
                    ppc_pkg::REG_SCALE_FACTOR: r_scale      <= i_cfg_wdata[2:0];
                    ppc_pkg::REG_RED_MASK:     r_red_mask   <= i_cfg_wdata;
                    ppc_pkg::REG_GREEN_MASK:   r_green_mask <= i_cfg_wdata;
                    ppc_pkg::REG_BLUE_MASK:    r_blue_mask  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (mask_wr) begin
                r_busy <= ppc_pkg::DECODE_LATENCY;
            end else if (r_busy != '0) begin
                r_busy <= r_busy - 2'd1;
            end
        end
    end

    ppc_field_decode u_red_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mask  (r_red_mask),
        .o_field (red_field)
    );

    ppc_field_decode u_green_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mask  (r_green_mask),
        .o_field (green_field)
    );

    ppc_field_decode u_blue_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mask  (r_blue_mask),
        .o_field (blue_field)
    );

    // top wid bits of the level, placed at the shift
    function automatic logic [31:0] place(input ppc_pkg::t_field f, input logic [7:0] level);
        logic [7:0] top;
        top = level >> (4'd8 - f.wid);
        return 32'(top) << f.sh;
    endfunction

    // request unpacking
    logic [7:0] in_index;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    assign in_index = s_axis_tdata[7:0];
    assign in_red   = s_axis_tdata[15:8];
    assign in_green = s_axis_tdata[23:16];
    assign in_blue  = s_axis_tdata[31:24];

    logic in_fire;
    logic pix_fire;
    logic in_range;
    logic [AW-1:0] in_addr;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign pix_fire = in_fire && (s_axis_tuser == ppc_pkg::REQ_PIXEL);
    assign in_range = {1'b0, in_index} < 9'(PALETTE_SIZE);
    assign in_addr  = in_index[AW-1:0];

    logic        ram_we;
    logic [31:0] ram_wdata;
    logic [31:0] ram_rdata;
    assign ram_we = in_fire && (s_axis_tuser == ppc_pkg::REQ_PALETTE_WRITE)
                    && (r_mode != ppc_pkg::MODE_INDEXED) && in_range;
    assign ram_wdata = place(red_field, in_red) | place(green_field, in_green)
                       | place(blue_field, in_blue);

    ppc_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_SIZE)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (in_addr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (pix_fire),
        .i_rd_addr (in_addr),
        .o_rd_data (ram_rdata)
    );

    // entries never written read as zero
    logic [PALETTE_SIZE-1:0] r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[in_addr] <= 1'b1;
        end
    end

    // table read stage
    logic       r_a_valid;
    logic [7:0] r_a_idx;
    logic       r_a_hit;

    // output repeat stage
    logic          r_o_valid;
    logic [31:0]   r_o_data;
    logic [RW-1:0] r_o_left;

    logic          o_fire;
    logic          o_last;
    logic          o_free;
    logic          a_adv;
    logic [RW-1:0] reps;
    logic [31:0]   word;

    assign o_last = r_o_left == RW'(1);
    assign o_fire = r_o_valid && m_axis_tready;
    assign o_free = !r_o_valid || (o_fire && o_last);
    assign a_adv  = r_a_valid && o_free;

    assign s_axis_tready = (r_busy == '0) && (!r_a_valid || o_free);

    always_comb begin
        if (r_scale == 3'd0) begin
            reps = RW'(1);
        end else if (4'(r_scale) > 4'(MAX_SCALE)) begin
            reps = RW'(MAX_SCALE);
        end else begin
            reps = RW'(r_scale);
        end
    end

    always_comb begin
        if (r_mode == ppc_pkg::MODE_INDEXED) begin
            word = 32'(r_a_idx);
        end else if (!r_a_hit) begin
            word = '0;
        end else if (r_mode == ppc_pkg::MODE_TC16) begin
            word = {16'd0, ram_rdata[15:0]};
        end else begin
            word = ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (pix_fire) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_a_idx <= in_index;
            r_a_hit <= in_range && r_valid[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_o_left  <= '0;
        end else if (a_adv) begin
            r_o_valid <= 1'b1;
            r_o_left  <= reps;
        end else if (o_fire) begin
            if (o_last) begin
                r_o_valid <= 1'b0;
            end
            r_o_left <= r_o_left - RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_o_data <= word;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_valid && o_last;

`ifndef SYNTHESIS
    a_mask_write_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mask_wr |=> !s_axis_tready)
        else $error("request taken while a mask is being decoded");

    a_left_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_left != '0) && (32'(r_o_left) <= 32'(MAX_SCALE)))
        else $error("repeat count out of range");

    a_read_stage_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_o_valid) |=> r_o_valid)
        else $error("pixel held in read stage with output empty");

    a_new_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv |=> r_o_valid && (r_o_left == $past(reps)))
        else $error("output run loaded with wrong count");
`endif

endmodule
